// ===== src/acos_pkg.sv =====
package acos_pkg;

   // Number of pipeline registers; the last one is the output register.
   localparam int NUM_STAGES = 37;
   localparam int LAST_STAGE = NUM_STAGES - 1;

   // First register of each section.
   localparam int SQRT_FIRST = 1;
   localparam int SQRT_STEPS = 30;
   localparam int SQRT_ROUND = SQRT_FIRST + SQRT_STEPS;
   localparam int DIV_FIRST  = 7;
   localparam int DIV_STEPS  = 28;
   localparam int PROD_STAGE = DIV_FIRST + DIV_STEPS;

   // Coefficients as n / 10^12 in Q30: n * 2^18 / 5^12, rounded.
   localparam longint unsigned FIVE_POW12      = 64'd244140625;
   localparam longint unsigned HALF_FIVE_POW12 = 64'd122070312;

   localparam logic [28:0] A0_Q30 =
      29'((64'd166665866970 * 64'd262144 + HALF_FIVE_POW12) / FIVE_POW12);
   localparam logic [25:0] A1_MAG =
      26'((64'd42743422091 * 64'd262144 + HALF_FIVE_POW12) / FIVE_POW12);
   localparam logic [23:0] A2_MAG =
      24'((64'd8656363003 * 64'd262144 + HALF_FIVE_POW12) / FIVE_POW12);
   localparam logic [29:0] B1_MAG =
      30'((64'd706629633900 * 64'd262144 + HALF_FIVE_POW12) / FIVE_POW12);

   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [16:0] ANGLE_MAX = 17'h1_FFFF;

   typedef struct packed {
      logic [16:0] span;      // 65536 - x; z = span * 2^13 in Q30
      logic [40:0] prod_a2;
      logic [46:0] prod_b1;
      logic [26:0] inner_mag; // inner is always negative
      logic [30:0] q_val;
      logic [43:0] prod_in;
      logic [28:0] p_val;
      logic [45:0] prod_p;
      logic [31:0] div_rem;
      logic [27:0] num_low;
      logic [27:0] quo;
      logic [29:0] root;
      logic [31:0] sq_rem;
      logic [29:0] s_val;
      logic [57:0] prod_rs;
      logic [16:0] angle;
   } stage_type;

   // One register stage of the pipeline; k is the register index.
   function automatic stage_type stage_fn(input int k, input stage_type a);
      stage_type   n;
      logic [59:0] radicand;
      logic [1:0]  pair;
      logic [33:0] sq_trial_rem;
      logic [31:0] sq_trial;
      logic [29:0] prod_mag;
      logic [29:0] p_signed;
      logic [28:0] zp;
      logic [58:0] numer;
      logic [32:0] div_shift;
      logic [27:0] t_val;
      logic [30:0] sum_val;
      logic [17:0] res;
      n = a;
      radicand = {a.span, 43'd0};
      pair = '0;
      sq_trial_rem = '0;
      sq_trial = {a.root, 2'b01};
      prod_mag = '0;
      p_signed = '0;
      zp = '0;
      numer = '0;
      div_shift = '0;
      t_val = '0;
      sum_val = '0;
      res = '0;

      // square root of z in Q30, two radicand bits a stage
      if (k >= SQRT_FIRST && k < SQRT_ROUND) begin
         pair = 2'(radicand >> (58 - 2 * (k - SQRT_FIRST)));
         sq_trial_rem = {a.sq_rem, pair};
         if (sq_trial_rem >= 34'(sq_trial)) begin
            n.sq_rem = 32'(sq_trial_rem - 34'(sq_trial));
            n.root   = {a.root[28:0], 1'b1};
         end else begin
            n.sq_rem = 32'(sq_trial_rem);
            n.root   = {a.root[28:0], 1'b0};
         end
      end
      if (k == SQRT_ROUND) begin
         n.s_val = a.root + 30'(a.sq_rem > 32'(a.root));
      end

      // restoring division, one quotient bit a stage
      if (k >= DIV_FIRST && k < PROD_STAGE) begin
         div_shift = {a.div_rem, 1'(a.num_low >> (27 - (k - DIV_FIRST)))};
         if (div_shift >= 33'(a.q_val)) begin
            n.div_rem = 32'(div_shift - 33'(a.q_val));
            n.quo     = {a.quo[26:0], 1'b1};
         end else begin
            n.div_rem = 32'(div_shift);
            n.quo     = {a.quo[26:0], 1'b0};
         end
      end

      case (k)
         1: begin
            n.prod_a2 = 41'(a.span) * 41'(A2_MAG);
            n.prod_b1 = 47'(a.span) * 47'(B1_MAG);
         end
         2: begin
            n.inner_mag = 27'(A1_MAG) + 27'((a.prod_a2 + 41'h1_0000) >> 17);
            n.q_val = ONE_Q30 - 31'((a.prod_b1 + 47'h1_0000) >> 17);
         end
         3: begin
            n.prod_in = 44'(a.span) * 44'(a.inner_mag);
         end
         4: begin
            prod_mag = 30'((a.prod_in + 44'h1_0000) >> 17);
            p_signed = 30'(A0_Q30) - prod_mag;
            // clamp: a negative p gives a product that is clamped to zero
            n.p_val = p_signed[29] ? 29'd0 : p_signed[28:0];
         end
         5: begin
            n.prod_p = 46'(a.span) * 46'(a.p_val);
         end
         6: begin
            zp = 29'((a.prod_p + 46'h1_0000) >> 17);
            numer = {zp, 30'd0} + 59'(a.q_val >> 1);
            n.div_rem = 32'(numer[58:28]);
            n.num_low = numer[27:0];
            n.quo = '0;
         end
         PROD_STAGE: begin
            n.prod_rs = 58'(a.quo) * 58'(a.s_val);
         end
         LAST_STAGE: begin
            t_val = 28'((a.prod_rs + 58'h2000_0000) >> 30);
            sum_val = 31'(a.s_val) + 31'(t_val);
            res = 18'((sum_val + 31'h1000) >> 13);
            n.angle = (res > 18'(ANGLE_MAX)) ? ANGLE_MAX : res[16:0];
         end
         default: begin
         end
      endcase
      return n;
   endfunction

endpackage

// ===== src/arccos_upper_range_rational.sv =====
// arccos(x) for x in [0.5, 1): x as unsigned Q0.16 in, angle in radians as
// unsigned Q1.16 out, rounded to nearest and saturated at 131071. The block
// is a 37-register pipeline with its result on the output register; one
// transaction is accepted every cycle while a stall at the output does not
// hold the pipeline. The length is set by the bit-per-stage divider for
// z*p/q and the square root of z that runs beside the polynomial stages.
// A stall at the output holds the pipeline back one stage at a time, so
// empty stages keep filling while a result waits.
module arccos_upper_range_rational
   import acos_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] arg_q16
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [16:0] angle_q16, [23:17] zero
);

   stage_type st_ff [NUM_STAGES];
   stage_type st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;

   // A stage advances when it is empty or the stage after it advances.
   assign adv[LAST_STAGE] = ~vld_ff[LAST_STAGE] | rsp_tready;
   for (genvar k = 0; k < LAST_STAGE; k++) begin : g_adv
      assign adv[k] = ~vld_ff[k] | adv[k + 1];
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[LAST_STAGE];
   assign rsp_tdata  = {7'd0, st_ff[LAST_STAGE].angle};

   always_comb begin
      st_in[0]      = '0;
      st_in[0].span = 17'h1_0000 - 17'(req_tdata);
      for (int k = 1; k < NUM_STAGES; k++) begin
         st_in[k] = stage_fn(k, st_ff[k - 1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

endmodule

// ===== dv/arccos_upper_range_rational_test.sv =====
module arccos_upper_range_rational_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  PIPE_DEPTH  = 37;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint ONE_Q30_V = 64'sd1 << 30;
   localparam longint COEF_A0 = (64'd166665866970 * 64'd262144 + 64'd122070312) / 64'd244140625;
   localparam longint COEF_A1 = -((64'd42743422091 * 64'd262144 + 64'd122070312) / 64'd244140625);
   localparam longint COEF_A2 = -((64'd8656363003 * 64'd262144 + 64'd122070312) / 64'd244140625);
   localparam longint COEF_B1 = -((64'd706629633900 * 64'd262144 + 64'd122070312) / 64'd244140625);

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] arg_q16
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [16:0] angle_q16, [23:17] zero

   logic [16:0] angle_queue[$];
   int          error_count;
   int          sent_count;
   int          recv_count;
   longint      cycle_count;
   bit          steady_mode;

   arccos_upper_range_rational u_dut (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic longint fix_mul(longint a, longint b);
      bit neg;
      longint unsigned ma, mb, m;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m = (ma * mb + (64'd1 << 29)) >> 30;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned round_sqrt(longint unsigned n);
      longint unsigned root, bitv, rem;
      root = 0;
      bitv = 64'd1 << 62;
      rem = n;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (rem > root) root += 1;
      return root;
   endfunction

   function automatic logic [16:0] arccos_angle(logic [15:0] arg);
      longint z, inner, p, q, zp, r, s, t, sum;
      longint unsigned uzp, uq, res;
      z = (64'd65536 - arg) << 13;
      inner = COEF_A1 + fix_mul(z, COEF_A2);
      p = COEF_A0 + fix_mul(z, inner);
      q = ONE_Q30_V + fix_mul(z, COEF_B1);
      zp = fix_mul(z, p);
      uzp = (zp < 0) ? 0 : zp;
      uq = (q < 1) ? 1 : q;
      r = ((uzp << 30) + (uq >> 1)) / uq;
      s = round_sqrt(longint'(z) << 30);
      t = fix_mul(r, s);
      sum = s + t;
      res = ((sum < 0 ? 0 : sum) + (64'd1 << 12)) >> 13;
      if (res > 131071) res = 131071;
      return res[16:0];
   endfunction

   // hold req_tvalid between back-to-back transactions; drop it only to idle
   task automatic send_arg(logic [15:0] arg);
      while (!steady_mode && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= arg;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      angle_queue.push_back(arccos_angle(arg));
      sent_count++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (angle_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      logic [15:0] args[$];
      args = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF, 16'h8001, 16'hFFFE,
               16'hC000, 16'hAAAA, 16'h5555, 16'hF000, 16'h0FFF, 16'hE666, 16'hB505};
      foreach (args[i]) send_arg(args[i]);
   endtask

   task automatic test_random_range();
      repeat (600) send_arg(16'($urandom_range(65535, 32768)));
   endtask

   task automatic test_full_range();
      repeat (200) send_arg(16'($urandom));
   endtask

   task automatic test_back_to_back();
      steady_mode = 1'b1;
      repeat (200) send_arg(16'($urandom_range(65535, 32768)));
      steady_mode = 1'b0;
   endtask

   // rsp_tready: random stalls except during the back-to-back phase
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady_mode || ($urandom_range(99) >= 7);
   end

   always @(posedge clock) begin
      logic [16:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         recv_count++;
         if (angle_queue.size() == 0) begin
            $error("unexpected transaction: angle_q16 = %0d", rsp_tdata[16:0]);
            error_count++;
         end else begin
            want = angle_queue.pop_front();
            if (rsp_tdata[16:0] !== want) begin
               $error("angle_q16: expected %0d, actual %0d", want, rsp_tdata[16:0]);
               error_count++;
            end
            if (rsp_tdata[23:17] !== 7'd0) begin
               $error("pad bits: expected 0, actual %0h", rsp_tdata[23:17]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      steady_mode = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      // hold off until every outstanding transaction has come back
      drain_results();
      test_random_range();
      test_back_to_back();
      test_full_range();
      drain_results();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (angle_queue.size() != 0) begin
         $error("angle_q16: expected %0d more transactions, actual 0", angle_queue.size());
         error_count++;
      end
      $display("Covered %0d arguments (%0d results): endpoints, below-half range,",
               sent_count, recv_count);
      $display("random stalls on both sides and a back-to-back burst.");
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
